[rtl/stlb_pkg.sv]
`default_nettype none
package stlb_pkg;

  // Field widths of the beats and the count register
  localparam int KEY_W = 64;
  localparam int IDX_W = 10;
  localparam int CNT_W = 11;

  // Item commands
  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;      // start a search: clear lower bound, load upper bound and key
    logic write;     // store the key of a write beat
    logic probe;     // register the bounds and issue the next table read
    logic step;      // narrow the bounds with the key just read
    logic res_load;  // capture the final position into the result register
  } ctrl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic more;      // lower bound still below upper bound: another probe follows
  } dp_status_t;

endpackage
`default_nettype wire

[rtl/stlb_if.sv]
`default_nettype none
// Item channel: one write or search beat
interface stlb_item_if;
  import stlb_pkg::*;
  logic                    valid;
  logic                    ready;
  logic                    cmd;
  logic [IDX_W-1:0]        entry_index;
  logic signed [KEY_W-1:0] key_value;

  modport source (output valid, cmd, entry_index, key_value, input ready);
  modport sink   (input valid, cmd, entry_index, key_value, output ready);
endinterface

// Result channel: one position per search
interface stlb_result_if;
  import stlb_pkg::*;
  logic             valid;
  logic             ready;
  logic [CNT_W-1:0] found_position;

  modport source (output valid, found_position, input ready);
  modport sink   (input valid, found_position, output ready);
endinterface
`default_nettype wire

[rtl/stlb_datapath.sv]
`default_nettype none
module stlb_datapath #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [stlb_pkg::CNT_W-1:0]      cfg_wr_data,
  input  logic [stlb_pkg::IDX_W-1:0]      entry_index,
  input  logic signed [stlb_pkg::KEY_W-1:0] key_value,
  input  stlb_pkg::ctrl_cmd_t             cmd,
  output stlb_pkg::dp_status_t            status,
  output logic [stlb_pkg::CNT_W-1:0]      found_position
);
  import stlb_pkg::*;

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  logic [CNT_W-1:0]        table_count;
  logic [CNT_W-1:0]        count_eff;
  logic signed [KEY_W-1:0] key;
  logic [CNT_W-1:0]        lo;
  logic [CNT_W-1:0]        hi;
  logic [CNT_W-1:0]        mid_q;
  logic [CNT_W-1:0]        lo_eff;
  logic [CNT_W-1:0]        hi_eff;
  logic [CNT_W-1:0]        mid;
  logic                    key_less;
  logic                    idx_ok;
  logic signed [KEY_W-1:0] rdata;
  logic signed [KEY_W-1:0] mem [TABLE_DEPTH];

  // Count register
  always_ff @(posedge clk) begin
    if (rst) begin
      table_count <= '0;
    end else if (cfg_wr_en) begin
      table_count <= cfg_wr_data;
    end
  end

  // Saturate the count at the table depth
  always_comb begin
    if (32'(table_count) > TABLE_DEPTH) begin
      count_eff = CNT_W'(TABLE_DEPTH);
    end else begin
      count_eff = table_count;
    end
  end

  // Narrow the bounds with the entry read at the last midpoint, then pick the next midpoint
  always_comb begin
    key_less = rdata < key;
    lo_eff   = lo;
    hi_eff   = hi;
    if (cmd.step) begin
      if (key_less) begin
        lo_eff = mid_q + CNT_W'(1);
      end else begin
        hi_eff = mid_q;
      end
    end
    mid         = lo_eff + ((hi_eff - lo_eff) >> 1);
    status.more = lo_eff < hi_eff;
  end

  // Search bounds, key and result
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lo  <= '0;
      hi  <= count_eff;
      key <= key_value;
    end else if (cmd.probe) begin
      lo    <= lo_eff;
      hi    <= hi_eff;
      mid_q <= mid;
    end
    if (cmd.res_load) begin
      found_position <= hi_eff;
    end
  end

  // Table memory: one write port, one registered read port
  assign idx_ok = 32'(entry_index) < TABLE_DEPTH;

  always_ff @(posedge clk) begin
    if (cmd.write && idx_ok) begin
      mem[AW'(entry_index)] <= key_value;
    end
    rdata <= mem[AW'(mid)];
  end

endmodule
`default_nettype wire

[rtl/stlb_ctrl.sv]
`default_nettype none
module stlb_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  input  logic                 item_cmd,
  output logic                 item_ready,
  output logic                 result_valid,
  input  logic                 result_ready,
  input  stlb_pkg::dp_status_t status,
  output stlb_pkg::ctrl_cmd_t  cmd
);
  import stlb_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_PROBE = 2'd1;
  localparam logic [1:0] ST_STEP  = 2'd2;
  localparam logic [1:0] ST_HOLD  = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;
  logic       slot_free;
  logic       searching;

  assign item_ready = (state == ST_IDLE);
  assign accept     = item_valid && item_ready;
  assign slot_free  = !result_valid || result_ready;
  assign searching  = (state == ST_PROBE) || (state == ST_STEP);

  // Decode commands
  always_comb begin
    cmd.load     = accept && (item_cmd == CMD_SEARCH);
    cmd.write    = accept && (item_cmd == CMD_WRITE);
    cmd.probe    = searching;
    cmd.step     = (state == ST_STEP);
    cmd.res_load = slot_free &&
                   ((searching && !status.more) || (state == ST_HOLD));
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (cmd.load) state_next = ST_PROBE;
      end
      ST_PROBE, ST_STEP: begin
        if (status.more)    state_next = ST_STEP;
        else if (slot_free) state_next = ST_IDLE;
        else                state_next = ST_HOLD;
      end
      ST_HOLD: begin
        if (slot_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // State and result valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      result_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.res_load) begin
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  // A new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (!result_valid || result_ready))
    else $error("result overwritten while waiting");

  // A step follows only a probe that left the bounds open
  a_step_after_more: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) |-> $past(status.more))
    else $error("step without open bounds");

  // A search beat starts the probe sequence on the next cycle
  a_load_probe: assert property (@(posedge clk) disable iff (rst)
    cmd.load |=> (state == ST_PROBE))
    else $error("search did not start probing");

  // Result loads only once the bounds have met
  a_load_when_done: assert property (@(posedge clk) disable iff (rst)
    cmd.res_load |-> (state == ST_HOLD || !status.more))
    else $error("result loaded before search ended");

endmodule
`default_nettype wire

[rtl/sorted_table_lower_bound.sv]
`default_nettype none
// Lower-bound search over a table of signed 64-bit keys held in ascending order.
// A write beat (cmd 0) stores key_value at entry_index and gives no result;
// indexes at or beyond TABLE_DEPTH are dropped. A search beat (cmd 1) returns
// the first position among the first table_count entries (saturated at
// TABLE_DEPTH) whose key is not below key_value, or that count if none is. The
// search probes the table memory once per cycle through its single registered
// read port. The item channel opens again on the cycle after the result is
// loaded, so a search holds the input until then. A finished search waits while
// an earlier result is still untaken. Entries must be written before a search can
// reach them. Write table_count only while no search is in flight.
module sorted_table_lower_bound #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [stlb_pkg::CNT_W-1:0] cfg_wr_data,
  stlb_item_if.sink                  item,
  stlb_result_if.source              result
);
  import stlb_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  stlb_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item.valid),
    .item_cmd     (item.cmd),
    .item_ready   (item.ready),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .status       (status),
    .cmd          (cmd)
  );

  stlb_datapath #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_wr_data    (cfg_wr_data),
    .entry_index    (item.entry_index),
    .key_value      (item.key_value),
    .cmd            (cmd),
    .status         (status),
    .found_position (result.found_position)
  );

endmodule
`default_nettype wire

[tb/tb_sorted_table_lower_bound.sv]
`default_nettype none
// Predicts the lower-bound position for every accepted search and checks the
// result beats against it in order.
class position_checker;
  localparam int DEPTH = 1024;

  logic signed [stlb_pkg::KEY_W-1:0] keys [DEPTH];
  bit                                written [DEPTH];
  logic [stlb_pkg::CNT_W-1:0]        table_count;
  logic [stlb_pkg::CNT_W-1:0]        positions_due [$];
  int                                fails;
  int                                positions_seen;
  int                                writes_taken;
  int                                searches_taken;

  function new();
    table_count    = '0;
    fails          = 0;
    positions_seen = 0;
    writes_taken   = 0;
    searches_taken = 0;
    foreach (keys[i]) begin
      keys[i]    = '0;
      written[i] = 1'b0;
    end
  endfunction

  function void set_count(logic [stlb_pkg::CNT_W-1:0] v);
    table_count = v;
  endfunction

  function int pending();
    return positions_due.size();
  endfunction

  // Halving search over the live entries, count saturated at the depth
  function logic [stlb_pkg::CNT_W-1:0] predict_position(logic signed [stlb_pkg::KEY_W-1:0] v);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = (table_count > DEPTH) ? DEPTH : int'(table_count);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (keys[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    return hi[stlb_pkg::CNT_W-1:0];
  endfunction

  // First entry a search for v would probe before it was ever written, else -1
  function int first_gap(logic signed [stlb_pkg::KEY_W-1:0] v);
    int lo;
    int hi;
    int mid;
    lo = 0;
    hi = (table_count > DEPTH) ? DEPTH : int'(table_count);
    while (lo < hi) begin
      mid = lo + (hi - lo) / 2;
      if (!written[mid]) return mid;
      if (keys[mid] < v) lo = mid + 1;
      else hi = mid;
    end
    return -1;
  endfunction

  // Apply one accepted item beat: store a key or queue the expected position
  function void note_item(logic c, logic [stlb_pkg::IDX_W-1:0] idx,
                          logic signed [stlb_pkg::KEY_W-1:0] k);
    if (c == stlb_pkg::CMD_WRITE) begin
      keys[idx]    = k;
      written[idx] = 1'b1;
      writes_taken++;
    end else begin
      positions_due.push_back(predict_position(k));
      searches_taken++;
    end
  endfunction

  // Compare one result beat with the oldest expected position
  function void check_position(logic [stlb_pkg::CNT_W-1:0] got);
    logic [stlb_pkg::CNT_W-1:0] want;
    positions_seen++;
    if (positions_due.size() == 0) begin
      $error("found_position: expected none, actual %0d", got);
      fails++;
    end else begin
      want = positions_due.pop_front();
      if (got !== want) begin
        $error("found_position: expected %0d, actual %0d", want, got);
        fails++;
      end
    end
  endfunction
endclass

module tb_sorted_table_lower_bound;
  timeunit 1ns;
  timeprecision 1ps;
  import stlb_pkg::*;

  localparam int DEPTH       = 1024;
  localparam int SETTLE      = 16;
  localparam int LONG_HOLD   = 400;
  localparam int FILL_LEN    = 128;
  localparam int RANDOM_BEATS = 600;
  localparam logic signed [KEY_W-1:0] KEY_MIN = 64'sh8000_0000_0000_0000;
  localparam logic signed [KEY_W-1:0] KEY_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;

  logic             clk = 1'b0;
  logic             rst;
  logic             cfg_wr_en;
  logic [CNT_W-1:0] cfg_wr_data;

  stlb_item_if   item_ch ();
  stlb_result_if result_ch ();

  position_checker positions = new();

  bit steady_send;
  bit long_hold_done;
  int count_writes;
  int random_beats;

  sorted_table_lower_bound #(.TABLE_DEPTH(DEPTH)) dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .item        (item_ch),
    .result      (result_ch)
  );

  always #4 clk = ~clk;

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [KEY_W-1:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // Offer one item beat and hold it until taken
  task automatic offer_beat(input logic c, input logic [IDX_W-1:0] idx,
                            input logic signed [KEY_W-1:0] k);
    int gap;
    gap = steady_send ? 0 : pick_gap();
    if (gap > 0) begin
      item_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_ch.valid       <= 1'b1;
    item_ch.cmd         <= c;
    item_ch.entry_index <= idx;
    item_ch.key_value   <= k;
    do @(posedge clk); while (!item_ch.ready);
    positions.note_item(c, idx, k);
  endtask

  // Drop valid and wait until every search has answered, then let writes settle
  task automatic wait_for_quiet();
    item_ch.valid <= 1'b0;
    while (positions.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_table_count(input logic [CNT_W-1:0] v);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
    positions.set_count(v);
    count_writes++;
  endtask

  // Write an ascending run of keys into entries lo .. hi-1
  task automatic load_sorted_run(input int lo, input int hi, input int step_shift);
    logic signed [KEY_W-1:0] cur;
    logic signed [KEY_W-1:0] delta;
    int i;
    cur = (step_shift >= 12) ? (KEY_MIN >>> 1) + (rand_key() >>> 4) : rand_key();
    for (i = lo; i < hi; i++) begin
      offer_beat(CMD_WRITE, i[IDX_W-1:0], cur);
      delta = ($urandom_range(0, 7) == 0) ? '0 :
              $signed(KEY_W'($unsigned(rand_key()) >> (step_shift + 1)));
      if (cur > KEY_MAX - delta) cur = KEY_MAX;
      else cur = cur + delta;
    end
  endtask

  // Search value picked against the live entries
  function automatic logic signed [KEY_W-1:0] pick_search_key(input int n);
    int r;
    int i;
    r = $urandom_range(0, 99);
    if (n > DEPTH) n = DEPTH;
    if (n > 0 && r < 40) return positions.keys[$urandom_range(0, n - 1)];
    if (n > 0 && r < 50) return positions.keys[$urandom_range(0, n - 1)] + 64'sd1;
    if (n > 0 && r < 60) return positions.keys[$urandom_range(0, n - 1)] - 64'sd1;
    if (r < 75) begin
      i = $urandom_range(0, 3);
      case (i)
        0: return KEY_MIN;
        1: return KEY_MAX;
        2: return '0;
        default: return -64'sd1;
      endcase
    end
    return rand_key();
  endfunction

  // Result side: random ready gaps, steady stretches and one long hold-off
  initial begin
    int gap;
    int steady_left;
    steady_left     = 0;
    long_hold_done  = 1'b0;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (!long_hold_done && positions.positions_seen >= 60) begin
        result_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        long_hold_done = 1'b1;
      end
      if (steady_left == 0 && $urandom_range(0, 9) == 0) steady_left = $urandom_range(10, 40);
      gap = (steady_left > 0) ? 0 : pick_gap();
      if (steady_left > 0) steady_left--;
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      positions.check_position(result_ch.found_position);
    end
  end

  // Stimulus
  initial begin
    int n;
    int ops;
    int r;
    int idx;
    int k;
    int gap_at;
    logic signed [KEY_W-1:0] search_key;
    rst                 <= 1'b1;
    cfg_wr_en           <= 1'b0;
    cfg_wr_data         <= '0;
    item_ch.valid       <= 1'b0;
    item_ch.cmd         <= CMD_WRITE;
    item_ch.entry_index <= '0;
    item_ch.key_value   <= '0;
    steady_send         = 1'b0;
    count_writes        = 0;
    random_beats        = 0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty table after reset: every search lands on zero
    offer_beat(CMD_SEARCH, '0, KEY_MIN);
    offer_beat(CMD_SEARCH, '1, KEY_MAX);

    // Four extreme keys, plus the top index
    offer_beat(CMD_WRITE, 10'd0, KEY_MIN);
    offer_beat(CMD_WRITE, 10'd1, -64'sd1);
    offer_beat(CMD_WRITE, 10'd2, 64'sd0);
    offer_beat(CMD_WRITE, 10'd3, KEY_MAX);
    offer_beat(CMD_WRITE, 10'd1023, KEY_MAX);
    wait_for_quiet();
    set_table_count(11'd4);
    offer_beat(CMD_SEARCH, 10'd0, KEY_MIN);
    offer_beat(CMD_SEARCH, 10'd1023, -64'sd1);
    offer_beat(CMD_SEARCH, 10'd512, 64'sd0);
    offer_beat(CMD_SEARCH, 10'd3, 64'sd1);
    offer_beat(CMD_SEARCH, 10'd0, KEY_MAX);
    offer_beat(CMD_SEARCH, 10'd0, KEY_MIN + 64'sd1);
    wait_for_quiet();
    set_table_count(11'd1);
    offer_beat(CMD_SEARCH, 10'd0, KEY_MIN);
    offer_beat(CMD_SEARCH, 10'd0, 64'sd0);
    wait_for_quiet();

    // Break the ordering: the halving steps still decide the answer
    set_table_count(11'd4);
    offer_beat(CMD_WRITE, 10'd2, KEY_MIN);
    offer_beat(CMD_SEARCH, 10'd0, -64'sd1);
    wait_for_quiet();

    // Fill the bottom of the table with ascending keys; higher entries are
    // filled when a search would first reach them
    steady_send = 1'b1;
    load_sorted_run(0, FILL_LEN, 13);
    steady_send = 1'b0;
    wait_for_quiet();

    // Random phases: pick a count, maybe reload a short sorted run, then mix beats
    while (random_beats < RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 10) n = 0;
      else if (r < 20) n = 1;
      else if (r < 30) n = $urandom_range(2, 3);
      else if (r < 60) n = $urandom_range(4, 40);
      else if (r < 70) n = $urandom_range(41, 1022);
      else if (r < 80) n = 1024;
      else if (r < 85) n = 1023;
      else if (r < 92) n = $urandom_range(1025, 2047);
      else n = 2047;
      set_table_count(n[CNT_W-1:0]);
      steady_send = ($urandom_range(0, 3) == 0);
      if (n > 0 && n <= 64 && $urandom_range(0, 1) == 0) begin
        load_sorted_run(0, n, $urandom_range(0, 62));
        random_beats += n;
      end
      ops = $urandom_range(8, 30);
      repeat (ops) begin
        r = $urandom_range(0, 99);
        if (r < 70) begin
          // Search, unless it would reach an entry never written: fill that one
          search_key = pick_search_key(n);
          gap_at     = positions.first_gap(search_key);
          if (gap_at < 0) begin
            idx = $urandom_range(0, DEPTH - 1);
            offer_beat(CMD_SEARCH, idx[IDX_W-1:0], search_key);
          end else begin
            offer_beat(CMD_WRITE, gap_at[IDX_W-1:0], KEY_W'(gap_at) <<< 52);
          end
        end else if (r < 85 || n >= DEPTH) begin
          // Rewrite an entry with its own key: order kept
          idx = $urandom_range(0, DEPTH - 1);
          offer_beat(CMD_WRITE, idx[IDX_W-1:0], positions.keys[idx]);
        end else if (r < 94) begin
          // Write outside the live range
          idx = $urandom_range(n, DEPTH - 1);
          offer_beat(CMD_WRITE, idx[IDX_W-1:0], rand_key());
        end else begin
          // Random key anywhere: may break the order
          idx = $urandom_range(0, DEPTH - 1);
          offer_beat(CMD_WRITE, idx[IDX_W-1:0], rand_key());
        end
        random_beats++;
      end
      wait_for_quiet();
    end

    for (k = 0; k < 1; k++) begin
      $display("Covered %0d write and %0d search beats over %0d count settings.",
               positions.writes_taken, positions.searches_taken, count_writes);
      $display("Checked %0d positions, receiver long hold-off %s.",
               positions.positions_seen, long_hold_done ? "done" : "not reached");
    end
    if (positions.fails == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
`default_nettype wire
